// File: hdl/cmc_pkg.sv
`default_nettype none

package cmc_pkg;

    typedef enum logic [2:0] {
        MODE_MANUAL     = 3'd0,
        MODE_AUTO       = 3'd1,
        MODE_SET_WATER  = 3'd2,
        MODE_SET_HUM    = 3'd3,
        MODE_SET_TEMP   = 3'd4,
        MODE_READ_LEVER = 3'd5
    } t_mode;

    typedef enum logic [2:0] {
        REG_WATER_INCR    = 3'd0,
        REG_WATER_LIMIT   = 3'd1,
        REG_HUM_STEP      = 3'd2,
        REG_HUM_LIMIT     = 3'd3,
        REG_TEMP_INCR     = 3'd4,
        REG_TEMP_FLOOR    = 3'd5,
        REG_TEMP_CEILING  = 3'd6,
        REG_UNUSED        = 3'd7
    } t_reg_idx;

    // drive bit positions: pump, fan, humidifier, heater
    localparam logic [3:0] DRV_FAN  = 4'b0010;
    localparam logic [3:0] DRV_HUM  = 4'b0100;
    localparam logic [3:0] DRV_HEAT = 4'b1000;

    localparam int ITEM_BITS   = 20;
    localparam int ITEM_BYTES  = 3;
    localparam int RES_BITS    = 37;
    localparam int RES_BYTES   = 5;
    localparam int APB_AW      = 5;

    localparam logic [11:0]        WATER_GOAL_RST = 12'd150;
    localparam logic [6:0]         HUM_GOAL_RST   = 7'd50;
    localparam logic signed [7:0]  TEMP_GOAL_RST  = 8'sd25;

    typedef struct packed {
        logic              lever_automatic;
        logic              press_up;
        logic              press_down;
        logic              press_settings;
        logic              sample_valid;
        logic signed [7:0] temperature;
        logic [6:0]        humidity;
    } t_item;

    typedef struct packed {
        logic [9:0]        water_incr;
        logic [11:0]       water_limit;
        logic [5:0]        humidity_step;
        logic [6:0]        humidity_limit;
        logic [4:0]        temp_incr;
        logic signed [7:0] temp_floor;
        logic signed [7:0] temp_ceiling;
    } t_cfg;

    typedef struct packed {
        t_mode             mode;
        logic [1:0]        dev;
        logic [3:0]        drive;
        logic              paused;
        logic [2:0]        pend;     // bit0 up, bit1 down, bit2 settings
        logic [11:0]       water;
        logic [6:0]        hum;
        logic signed [7:0] temp;
    } t_state;

endpackage

`default_nettype wire

// File: hdl/cmc_cfg_regs.sv
`default_nettype none

module cmc_cfg_regs (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [cmc_pkg::APB_AW-1:0]   paddr,
    input  wire logic [31:0]                  pwdata,
    output logic      [31:0]                  prdata,
    output logic                              pready,
    output cmc_pkg::t_cfg                     o_cfg
);
    import cmc_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign w_idx  = t_reg_idx'(paddr[APB_AW-1:2]);
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.water_incr     <= 10'd10;
            r_cfg.water_limit    <= 12'd500;
            r_cfg.humidity_step  <= 6'd5;
            r_cfg.humidity_limit <= 7'd100;
            r_cfg.temp_incr      <= 5'd1;
            r_cfg.temp_floor     <= 8'sd10;
            r_cfg.temp_ceiling   <= 8'sd40;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_WATER_INCR:   r_cfg.water_incr     <= pwdata[9:0];
                REG_WATER_LIMIT:  r_cfg.water_limit    <= pwdata[11:0];
                REG_HUM_STEP:     r_cfg.humidity_step  <= pwdata[5:0];
                REG_HUM_LIMIT:    r_cfg.humidity_limit <= pwdata[6:0];
                REG_TEMP_INCR:    r_cfg.temp_incr      <= pwdata[4:0];
                REG_TEMP_FLOOR:   r_cfg.temp_floor     <= pwdata[7:0];
                REG_TEMP_CEILING: r_cfg.temp_ceiling   <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_WATER_INCR:   prdata = {22'd0, r_cfg.water_incr};
            REG_WATER_LIMIT:  prdata = {20'd0, r_cfg.water_limit};
            REG_HUM_STEP:     prdata = {26'd0, r_cfg.humidity_step};
            REG_HUM_LIMIT:    prdata = {25'd0, r_cfg.humidity_limit};
            REG_TEMP_INCR:    prdata = {27'd0, r_cfg.temp_incr};
            REG_TEMP_FLOOR:   prdata = {24'd0, r_cfg.temp_floor};
            REG_TEMP_CEILING: prdata = {24'd0, r_cfg.temp_ceiling};
            default:          prdata = 32'd0;
        endcase
    end

endmodule

`default_nettype wire

// File: hdl/cmc_next.sv
`default_nettype none

module cmc_next (
    input  wire cmc_pkg::t_state i_state,
    input  wire cmc_pkg::t_item  i_item,
    input  wire cmc_pkg::t_cfg   i_cfg,
    output cmc_pkg::t_state      o_state
);
    import cmc_pkg::*;

    logic [2:0]        w_pend;
    logic [3:0]        w_bit;
    logic [3:0]        w_drv;

    // water target arithmetic
    logic [12:0]       w_wsum;
    logic [11:0]       w_wstep;
    logic [11:0]       w_w1;
    logic [11:0]       w_w2;

    // humidity target arithmetic
    logic [7:0]        w_hsum;
    logic [6:0]        w_hstep;
    logic [6:0]        w_h1;
    logic [6:0]        w_h2;
    logic signed [8:0] w_hlo;
    logic signed [8:0] w_hmeas;

    // temperature target arithmetic
    logic signed [9:0] w_tgoal;
    logic signed [9:0] w_tstep;
    logic signed [9:0] w_thi;
    logic signed [9:0] w_tlo;
    logic signed [9:0] w_tceil;
    logic signed [9:0] w_tfloor;
    logic signed [9:0] w_tmeas;
    logic signed [7:0] w_t1;
    logic signed [9:0] w_t1x;
    logic signed [9:0] w_tdn;
    logic signed [7:0] w_t2;

    assign w_pend = i_state.pend
                  | {i_item.press_settings, i_item.press_down, i_item.press_up};
    assign w_bit  = 4'b0001 << i_state.dev;

    assign w_wsum  = {1'b0, i_state.water} + {3'b000, i_cfg.water_incr};
    assign w_wstep = {2'b00, i_cfg.water_incr};
    assign w_w1    = !w_pend[0] ? i_state.water :
                     (w_wsum > {1'b0, i_cfg.water_limit}) ? i_cfg.water_limit : w_wsum[11:0];
    assign w_w2    = !w_pend[1] ? w_w1 : (w_w1 <= w_wstep) ? 12'd0 : w_w1 - w_wstep;

    assign w_hsum  = {1'b0, i_state.hum} + {2'b00, i_cfg.humidity_step};
    assign w_hstep = {1'b0, i_cfg.humidity_step};
    assign w_h1    = !w_pend[0] ? i_state.hum :
                     (w_hsum > {1'b0, i_cfg.humidity_limit}) ? i_cfg.humidity_limit
                                                              : w_hsum[6:0];
    assign w_h2    = !w_pend[1] ? w_h1 : (w_h1 <= w_hstep) ? 7'd0 : w_h1 - w_hstep;
    assign w_hlo   = $signed({2'b00, i_state.hum}) - $signed({3'b000, i_cfg.humidity_step});
    assign w_hmeas = $signed({2'b00, i_item.humidity});

    assign w_tgoal  = {{2{i_state.temp[7]}}, i_state.temp};
    assign w_tstep  = $signed({5'd0, i_cfg.temp_incr});
    assign w_thi    = w_tgoal + w_tstep;
    assign w_tlo    = w_tgoal - w_tstep;
    assign w_tceil  = {{2{i_cfg.temp_ceiling[7]}}, i_cfg.temp_ceiling};
    assign w_tfloor = {{2{i_cfg.temp_floor[7]}}, i_cfg.temp_floor};
    assign w_tmeas  = {{2{i_item.temperature[7]}}, i_item.temperature};
    assign w_t1     = !w_pend[0] ? i_state.temp :
                      (w_thi > w_tceil) ? i_cfg.temp_ceiling : w_thi[7:0];
    assign w_t1x    = {{2{w_t1[7]}}, w_t1};
    assign w_tdn    = w_t1x - w_tstep;
    assign w_t2     = !w_pend[1] ? w_t1 :
                      (w_tdn < w_tfloor) ? i_cfg.temp_floor : w_tdn[7:0];

    always_comb begin
        o_state = i_state;
        w_drv   = i_state.drive;
        unique case (i_state.mode)
            MODE_MANUAL: begin
                if (w_pend[0]) w_drv = w_drv | w_bit;
                if (w_pend[1]) w_drv = w_drv & ~w_bit;
                if (w_pend[2]) begin
                    w_drv       = w_drv & ~w_bit;
                    o_state.dev = i_state.dev + 2'd1;
                end
                o_state.pend  = 3'b000;
                o_state.drive = w_drv;
                if (i_item.lever_automatic) begin
                    o_state.mode   = MODE_AUTO;
                    o_state.drive  = 4'b0000;
                    o_state.paused = 1'b0;
                end
            end
            MODE_AUTO: begin
                if (i_item.sample_valid) begin
                    if (w_tmeas > w_thi)      w_drv = (w_drv | DRV_FAN) & ~DRV_HEAT;
                    else if (w_tmeas < w_tlo) w_drv = (w_drv | DRV_HEAT) & ~DRV_FAN;
                    if (w_hmeas < w_hlo)                   w_drv = w_drv | DRV_HUM;
                    else if (i_item.humidity > i_state.hum) w_drv = w_drv & ~DRV_HUM;
                end
                o_state.drive = w_drv;
                if (w_pend[2]) begin
                    o_state.pend   = 3'b000;
                    o_state.paused = 1'b1;
                    o_state.mode   = MODE_SET_WATER;
                end else begin
                    // up and down wait here until a settings press clears them
                    o_state.pend = w_pend;
                    if (!i_item.lever_automatic) begin
                        o_state.mode   = MODE_MANUAL;
                        o_state.dev    = 2'd0;
                        o_state.paused = 1'b1;
                    end
                end
            end
            MODE_SET_WATER: begin
                o_state.water = w_w2;
                o_state.pend  = 3'b000;
                if (w_pend[2]) o_state.mode = MODE_SET_HUM;
            end
            MODE_SET_HUM: begin
                o_state.hum  = w_h2;
                o_state.pend = 3'b000;
                if (w_pend[2]) o_state.mode = MODE_SET_TEMP;
            end
            MODE_SET_TEMP: begin
                o_state.temp = w_t2;
                o_state.pend = 3'b000;
                if (w_pend[2]) begin
                    if (i_item.lever_automatic) begin
                        o_state.mode   = MODE_AUTO;
                        o_state.drive  = 4'b0000;
                        o_state.paused = 1'b0;
                    end else begin
                        o_state.mode   = MODE_MANUAL;
                        o_state.dev    = 2'd0;
                        o_state.paused = 1'b1;
                    end
                end
            end
            default: begin
                // first pass after reset: take the lever as it stands, keep presses
                o_state.pend = w_pend;
                if (i_item.lever_automatic) begin
                    o_state.mode   = MODE_AUTO;
                    o_state.drive  = 4'b0000;
                    o_state.paused = 1'b0;
                end else begin
                    o_state.mode   = MODE_MANUAL;
                    o_state.dev    = 2'd0;
                    o_state.paused = 1'b1;
                end
            end
        endcase
    end

endmodule

`default_nettype wire

// File: hdl/climate_mode_controller_top.sv
`default_nettype none

// Climate mode controller. Each input transfer is one pass of the control loop
// (lever, button presses, optional sensor sample) and yields exactly one result
// transfer with the mode, manual device selection, the four drive bits, the pause
// flag and the three targets after that pass. One transfer is taken per clock
// while the result register is free or draining; a pass goes through an input
// register and one level of next-state logic into the result register. Settings
// registers sit on the APB port at byte address 4*i; the user must write them only
// while the block is idle, which the block itself does not enforce.

module climate_mode_controller_top (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_rst_n,
    input  wire logic                                    i_s_tvalid,
    output logic                                         o_s_tready,
    // lever_automatic, press_up, press_down, press_settings, sample_valid,
    // temperature[7:0], humidity[6:0], zero pad
    input  wire logic [cmc_pkg::ITEM_BYTES*8-1:0]        i_s_tdata,
    output logic                                         o_m_tvalid,
    input  wire logic                                    i_m_tready,
    // mode[2:0], selected_device[1:0], pump_on, fan_on, humidifier_on, heater_on,
    // outputs_paused, water_level_target[11:0], humidity_target[6:0],
    // temperature_target[7:0], zero pad
    output logic      [cmc_pkg::RES_BYTES*8-1:0]         o_m_tdata,
    input  wire logic                                    psel,
    input  wire logic                                    penable,
    input  wire logic                                    pwrite,
    input  wire logic [cmc_pkg::APB_AW-1:0]              paddr,
    input  wire logic [31:0]                             pwdata,
    output logic      [31:0]                             prdata,
    output logic                                         pready
);
    import cmc_pkg::*;

    t_cfg                  w_cfg;
    t_item                 w_item;
    t_item                 r_item;
    logic                  r_in_valid;
    t_state                r_state;
    t_state                n_state;
    logic                  r_out_valid;
    logic [RES_BITS-1:0]   r_out_data;
    logic [RES_BITS-1:0]   n_out_data;
    logic                  w_fire;

    cmc_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    cmc_next u_next (
        .i_state (r_state),
        .i_item  (r_item),
        .i_cfg   (w_cfg),
        .o_state (n_state)
    );

    assign w_item.lever_automatic = i_s_tdata[0];
    assign w_item.press_up        = i_s_tdata[1];
    assign w_item.press_down      = i_s_tdata[2];
    assign w_item.press_settings  = i_s_tdata[3];
    assign w_item.sample_valid    = i_s_tdata[4];
    assign w_item.temperature     = i_s_tdata[12:5];
    assign w_item.humidity        = i_s_tdata[ITEM_BITS-1:13];

    // advance the held item whenever the result register is free or draining
    assign w_fire     = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || w_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_item <= w_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.mode   <= MODE_READ_LEVER;
            r_state.dev    <= 2'd0;
            r_state.drive  <= 4'b0000;
            r_state.paused <= 1'b1;
            r_state.pend   <= 3'b000;
            r_state.water  <= WATER_GOAL_RST;
            r_state.hum    <= HUM_GOAL_RST;
            r_state.temp   <= TEMP_GOAL_RST;
        end else if (w_fire) begin
            r_state <= n_state;
        end
    end

    assign n_out_data = {n_state.temp, n_state.hum, n_state.water, n_state.paused,
                         n_state.drive, n_state.dev, n_state.mode};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(RES_BYTES*8-RES_BITS){1'b0}}, r_out_data};

    a_no_read_lever_after_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire |=> r_state.mode != MODE_READ_LEVER)
        else $error("mode still waits for lever after a pass");

    a_auto_fan_heat_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.mode == MODE_AUTO |-> !(r_state.drive[1] && r_state.drive[3]))
        else $error("fan and heater both on in automatic mode");

    a_auto_not_paused: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.mode == MODE_AUTO |-> !r_state.paused)
        else $error("outputs paused in automatic mode");

    a_screen_no_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.mode == MODE_SET_WATER || r_state.mode == MODE_SET_HUM ||
         r_state.mode == MODE_SET_TEMP) |-> r_state.pend == 3'b000)
        else $error("presses left pending on a setting screen");

endmodule

`default_nettype wire
